### rtl/pwa_pkg.sv
// Shared types and constants of the PID controller with anti-windup.
// Depends on nothing; pwa_dp, pwa_ctrl and the top level refer to it by scoped names.
`default_nettype none

package pwa_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_MIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_MAX   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WINDUP_MODE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_MIN   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_MAX   = 3'd7;

   // anti-windup modes
   localparam logic [1:0] MODE_NONE     = 2'd0;
   localparam logic [1:0] MODE_CLAMP    = 2'd1;
   localparam logic [1:0] MODE_BACKCALC = 2'd2;
   localparam logic [1:0] MODE_COND     = 2'd3;

   // soft start factor, Q1.16
   localparam logic [16:0] SOFT_INIT = 17'd6554;
   localparam logic [16:0] SOFT_ONE  = 17'd65536;

   typedef struct packed {
      logic signed [31:0] measured;
      logic signed [31:0] setpoint;
      logic [31:0]        time_step;
      logic               restart;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               limited;
   } rsp_type;

   typedef enum logic [2:0] {
      MSRC_DT_EB,
      MSRC_GP_E,
      MSRC_GI_INT,
      MSRC_GD_Q,
      MSRC_S_SOFT
   } mul_src_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD_HI
   } acc_op_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_ACCEPT,
      ACT_LOAD,
      ACT_TERM,
      ACT_INTEG,
      ACT_CLAMP,
      ACT_ADD,
      ACT_QFIX,
      ACT_LIMIT,
      ACT_RESID,
      ACT_FIN
   } act_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MLO,
      ST_MHI,
      ST_MACC,
      ST_TERM,
      ST_INTEG,
      ST_CLAMP,
      ST_ADD,
      ST_WAITDIV,
      ST_QFIX,
      ST_LIMIT,
      ST_RESID,
      ST_SLO,
      ST_FIN
   } state_type;

   typedef struct packed {
      act_type     act;
      logic        mul_en;
      logic        mul_hi;
      mul_src_type mul_src;
      acc_op_type  acc_op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

endpackage

`default_nettype wire

### rtl/pwa_div.sv
// Serial signed divider for the derivative rate, two quotient bits per cycle.
// Depends on nothing beyond its parameter.
`default_nettype none

module pwa_div #(
   parameter int  FRAC_BITS = 16,
   localparam int NUM_W     = 33 + FRAC_BITS,
   localparam int QUOT_W    = NUM_W + (NUM_W % 2)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [32:0]   diff,
   input  logic [31:0]          divisor,
   output logic                 busy,
   output logic [QUOT_W-1:0]    quot,
   output logic                 neg
);

   localparam int ITER  = QUOT_W / 2;
   localparam int CNT_W = $clog2(ITER + 1);

   logic [QUOT_W-1:0] num_ff, num_in;
   logic [31:0]       rem_ff, rem_in;
   logic [31:0]       den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              neg_ff, neg_in;
   logic [32:0]       mag;
   logic [32:0]       t1, t2;
   logic [31:0]       r1, r2;
   logic              q1, q2;

   always_comb begin
      mag = diff[32] ? 33'(-diff) : 33'(diff);
      // first restoring step
      t1 = {rem_ff, num_ff[QUOT_W-1]};
      if (t1 >= {1'b0, den_ff}) begin
         r1 = 32'(t1 - {1'b0, den_ff});
         q1 = 1'b1;
      end else begin
         r1 = t1[31:0];
         q1 = 1'b0;
      end
      // second restoring step
      t2 = {r1, num_ff[QUOT_W-2]};
      if (t2 >= {1'b0, den_ff}) begin
         r2 = 32'(t2 - {1'b0, den_ff});
         q2 = 1'b1;
      end else begin
         r2 = t2[31:0];
         q2 = 1'b0;
      end

      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      if (start) begin
         num_in  = QUOT_W'({mag, {FRAC_BITS{1'b0}}});
         rem_in  = '0;
         den_in  = (divisor == 32'd0) ? 32'd1 : divisor;
         neg_in  = diff[32];
         cnt_in  = CNT_W'(ITER);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[QUOT_W-3:0], q1, q2};
         rem_in = r2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign busy = busy_ff;
   assign quot = num_ff;
   assign neg  = neg_ff;

endmodule

`default_nettype wire

### rtl/pwa_dp.sv
// Datapath: configuration registers, loop state, shared multiplier and accumulator.
// Depends on pwa_pkg and pwa_div.
`default_nettype none

module pwa_dp #(
   parameter int FRAC_BITS       = 16,
   parameter int BACK_CALC_SHIFT = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [pwa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pwa_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  pwa_pkg::req_type                    req_data,
   input  pwa_pkg::cmd_type                    cmd,
   output pwa_pkg::status_type                 status,
   output pwa_pkg::rsp_type                    rsp_data
);

   localparam int NUM_W  = 33 + FRAC_BITS;
   localparam int QUOT_W = NUM_W + (NUM_W % 2);

   function automatic logic signed [31:0] sat_32(input logic signed [32:0] x);
      logic signed [31:0] r;
      if (x[32] != x[31]) begin
         r = x[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [47:0] sat_48(input logic signed [81:0] x);
      logic signed [47:0] r;
      if ((&x[81:47]) || !(|x[81:47])) begin
         r = x[47:0];
      end else begin
         r = x[81] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [32:0] sat_33(input logic signed [51:0] x);
      logic signed [32:0] r;
      if ((&x[51:32]) || !(|x[51:32])) begin
         r = x[32:0];
      end else begin
         r = x[51] ? {1'b1, 32'b0} : {1'b0, {32{1'b1}}};
      end
      return r;
   endfunction

   logic signed [31:0] gain_p_ff, gain_p_in, gain_i_ff, gain_i_in, gain_d_ff, gain_d_in;
   logic signed [31:0] drive_min_ff, drive_min_in, drive_max_ff, drive_max_in;
   logic [1:0]         mode_ff, mode_in;
   logic signed [47:0] integ_min_ff, integ_min_in, integ_max_ff, integ_max_in;

   logic signed [47:0] integ_ff, integ_in;
   logic signed [31:0] prev_err_ff, prev_err_in, prev_drive_ff, prev_drive_in;
   logic signed [32:0] resid_ff, resid_in;
   logic [16:0]        soft_ff, soft_in;

   logic [31:0]        dt_ff, dt_in;
   logic signed [31:0] err_ff, err_in, s_ff, s_in;
   logic signed [33:0] eb_ff, eb_in;
   logic               pause_ff, pause_in, lim_ff, lim_in;
   logic signed [50:0] u_ff, u_in;
   logic signed [47:0] term_ff, term_in, q_ff, q_in;
   logic signed [57:0] prod_ff, prod_in;
   logic signed [81:0] acc_ff, acc_in;
   pwa_pkg::rsp_type   rsp_ff, rsp_in;

   logic signed [32:0] bc;
   logic signed [32:0] op_a;
   logic signed [47:0] op_b;
   logic signed [24:0] b_part;
   logic signed [50:0] s_tmp;
   logic signed [47:0] clamp_tmp;
   logic signed [31:0] drv;
   logic [17:0]        soft_dbl;
   logic [63:0]        mag64;
   logic               div_busy, div_neg;
   logic [QUOT_W-1:0]  div_quot;

   pwa_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.act == pwa_pkg::ACT_LOAD),
      .diff    (33'(err_ff) - 33'(prev_err_ff)),
      .divisor (dt_ff),
      .busy    (div_busy),
      .quot    (div_quot),
      .neg     (div_neg)
   );

   always_comb begin
      bc = (mode_ff == pwa_pkg::MODE_BACKCALC) ? (resid_ff >>> BACK_CALC_SHIFT) : 33'sd0;

      // shared multiplier operands
      case (cmd.mul_src)
         pwa_pkg::MSRC_DT_EB: begin
            op_a = {1'b0, dt_ff};
            op_b = 48'(eb_ff);
         end
         pwa_pkg::MSRC_GP_E: begin
            op_a = 33'(gain_p_ff);
            op_b = 48'(err_ff);
         end
         pwa_pkg::MSRC_GI_INT: begin
            op_a = 33'(gain_i_ff);
            op_b = integ_ff;
         end
         pwa_pkg::MSRC_GD_Q: begin
            op_a = 33'(gain_d_ff);
            op_b = q_ff;
         end
         pwa_pkg::MSRC_S_SOFT: begin
            op_a = 33'(s_ff);
            op_b = {31'b0, soft_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      b_part = cmd.mul_hi ? {op_b[47], op_b[47:24]} : {1'b0, op_b[23:0]};
      prod_in = cmd.mul_en ? (op_a * b_part) : prod_ff;

      case (cmd.acc_op)
         pwa_pkg::ACC_LOAD:   acc_in = 82'(prod_ff);
         pwa_pkg::ACC_ADD_HI: acc_in = acc_ff + (82'(prod_ff) <<< 24);
         default:             acc_in = acc_ff;
      endcase

      gain_p_in     = gain_p_ff;
      gain_i_in     = gain_i_ff;
      gain_d_in     = gain_d_ff;
      drive_min_in  = drive_min_ff;
      drive_max_in  = drive_max_ff;
      mode_in       = mode_ff;
      integ_min_in  = integ_min_ff;
      integ_max_in  = integ_max_ff;
      integ_in      = integ_ff;
      prev_err_in   = prev_err_ff;
      prev_drive_in = prev_drive_ff;
      resid_in      = resid_ff;
      soft_in       = soft_ff;
      dt_in         = dt_ff;
      err_in        = err_ff;
      s_in          = s_ff;
      eb_in         = eb_ff;
      pause_in      = pause_ff;
      lim_in        = lim_ff;
      u_in          = u_ff;
      term_in       = term_ff;
      q_in          = q_ff;
      rsp_in        = rsp_ff;

      s_tmp     = '0;
      clamp_tmp = integ_ff;
      drv       = prod_ff[47:16];
      soft_dbl  = {soft_ff, 1'b0};
      mag64     = 64'(div_quot);

      if (csr_valid) begin
         case (csr_index)
            pwa_pkg::REG_GAIN_P:      gain_p_in    = csr_wdata[31:0];
            pwa_pkg::REG_GAIN_I:      gain_i_in    = csr_wdata[31:0];
            pwa_pkg::REG_GAIN_D:      gain_d_in    = csr_wdata[31:0];
            pwa_pkg::REG_DRIVE_MIN:   drive_min_in = csr_wdata[31:0];
            pwa_pkg::REG_DRIVE_MAX:   drive_max_in = csr_wdata[31:0];
            pwa_pkg::REG_WINDUP_MODE: mode_in      = csr_wdata[1:0];
            pwa_pkg::REG_INTEG_MIN:   integ_min_in = csr_wdata[47:0];
            pwa_pkg::REG_INTEG_MAX:   integ_max_in = csr_wdata[47:0];
            default: ;
         endcase
      end

      case (cmd.act)
         pwa_pkg::ACT_ACCEPT: begin
            dt_in  = req_data.time_step;
            err_in = sat_32(33'(req_data.setpoint) - 33'(req_data.measured));
            if (req_data.restart) begin
               integ_in      = '0;
               prev_err_in   = '0;
               prev_drive_in = '0;
               soft_in       = pwa_pkg::SOFT_INIT;
            end
         end
         pwa_pkg::ACT_LOAD: begin
            eb_in    = 34'(err_ff) + 34'(bc);
            u_in     = 51'(bc);
            pause_in = (mode_ff == pwa_pkg::MODE_COND) &&
                       ((prev_drive_ff == drive_min_ff) || (prev_drive_ff == drive_max_ff)) &&
                       (err_ff[31] == prev_drive_ff[31]);
         end
         pwa_pkg::ACT_TERM: begin
            term_in = sat_48(acc_ff >>> FRAC_BITS);
         end
         pwa_pkg::ACT_INTEG: begin
            if (!pause_ff) begin
               integ_in = sat_48(82'(integ_ff) + 82'(term_ff));
            end
         end
         pwa_pkg::ACT_CLAMP: begin
            if (mode_ff == pwa_pkg::MODE_CLAMP) begin
               if (clamp_tmp < integ_min_ff) clamp_tmp = integ_min_ff;
               if (clamp_tmp > integ_max_ff) clamp_tmp = integ_max_ff;
               integ_in = clamp_tmp;
            end
         end
         pwa_pkg::ACT_ADD: begin
            u_in = u_ff + 51'(term_ff);
         end
         pwa_pkg::ACT_QFIX: begin
            if (div_neg) begin
               q_in = (mag64 > 64'h0000_8000_0000_0000) ? {1'b1, 47'b0}
                                                        : 48'(48'd0 - mag64[47:0]);
            end else begin
               q_in = (mag64 > 64'h0000_7FFF_FFFF_FFFF) ? {1'b0, {47{1'b1}}}
                                                        : mag64[47:0];
            end
         end
         pwa_pkg::ACT_LIMIT: begin
            // lower limit first, upper wins when they cross
            s_tmp = (u_ff < 51'(drive_min_ff)) ? 51'(drive_min_ff) : u_ff;
            if (s_tmp > 51'(drive_max_ff)) s_tmp = 51'(drive_max_ff);
            s_in   = s_tmp[31:0];
            lim_in = (u_ff > 51'(drive_max_ff)) || (u_ff < 51'(drive_min_ff));
         end
         pwa_pkg::ACT_RESID: begin
            if (mode_ff == pwa_pkg::MODE_BACKCALC) begin
               resid_in = sat_33(52'(s_ff) - 52'(u_ff));
            end
         end
         pwa_pkg::ACT_FIN: begin
            rsp_in.drive   = drv;
            rsp_in.limited = lim_ff;
            prev_err_in    = err_ff;
            prev_drive_in  = drv;
            soft_in = (soft_dbl > 18'(pwa_pkg::SOFT_ONE)) ? pwa_pkg::SOFT_ONE : soft_dbl[16:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      dt_ff    <= dt_in;
      err_ff   <= err_in;
      s_ff     <= s_in;
      eb_ff    <= eb_in;
      pause_ff <= pause_in;
      lim_ff   <= lim_in;
      u_ff     <= u_in;
      term_ff  <= term_in;
      q_ff     <= q_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         drive_min_ff  <= {1'b1, 31'b0};
         drive_max_ff  <= {1'b0, {31{1'b1}}};
         mode_ff       <= pwa_pkg::MODE_NONE;
         integ_min_ff  <= {1'b1, 47'b0};
         integ_max_ff  <= {1'b0, {47{1'b1}}};
         integ_ff      <= '0;
         prev_err_ff   <= '0;
         prev_drive_ff <= '0;
         resid_ff      <= '0;
         soft_ff       <= pwa_pkg::SOFT_INIT;
      end else begin
         gain_p_ff     <= gain_p_in;
         gain_i_ff     <= gain_i_in;
         gain_d_ff     <= gain_d_in;
         drive_min_ff  <= drive_min_in;
         drive_max_ff  <= drive_max_in;
         mode_ff       <= mode_in;
         integ_min_ff  <= integ_min_in;
         integ_max_ff  <= integ_max_in;
         integ_ff      <= integ_in;
         prev_err_ff   <= prev_err_in;
         prev_drive_ff <= prev_drive_in;
         resid_ff      <= resid_in;
         soft_ff       <= soft_in;
      end
   end

   assign status.div_busy = div_busy;
   assign rsp_data        = rsp_ff;

endmodule

`default_nettype wire

### rtl/pwa_ctrl.sv
// Sequencer of the PID step: handshakes and commands for the datapath.
// Depends on pwa_pkg.
`default_nettype none

module pwa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pwa_pkg::status_type  status,
   output pwa_pkg::cmd_type     cmd
);

   pwa_pkg::state_type   state_ff, state_in;
   pwa_pkg::mul_src_type op_ff, op_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwa_pkg::ST_IDLE;
         op_ff        <= pwa_pkg::MSRC_DT_EB;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      req_ready   = 1'b0;
      cmd.act     = pwa_pkg::ACT_NONE;
      cmd.mul_en  = 1'b0;
      cmd.mul_hi  = 1'b0;
      cmd.mul_src = op_ff;
      cmd.acc_op  = pwa_pkg::ACC_NONE;

      case (state_ff)
         pwa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.act  = pwa_pkg::ACT_ACCEPT;
               state_in = pwa_pkg::ST_LOAD;
            end
         end
         pwa_pkg::ST_LOAD: begin
            cmd.act  = pwa_pkg::ACT_LOAD;
            op_in    = pwa_pkg::MSRC_DT_EB;
            state_in = pwa_pkg::ST_MLO;
         end
         pwa_pkg::ST_MLO: begin
            cmd.mul_en = 1'b1;
            state_in   = pwa_pkg::ST_MHI;
         end
         pwa_pkg::ST_MHI: begin
            cmd.mul_en = 1'b1;
            cmd.mul_hi = 1'b1;
            cmd.acc_op = pwa_pkg::ACC_LOAD;
            state_in   = pwa_pkg::ST_MACC;
         end
         pwa_pkg::ST_MACC: begin
            cmd.acc_op = pwa_pkg::ACC_ADD_HI;
            state_in   = pwa_pkg::ST_TERM;
         end
         pwa_pkg::ST_TERM: begin
            cmd.act  = pwa_pkg::ACT_TERM;
            state_in = (op_ff == pwa_pkg::MSRC_DT_EB) ? pwa_pkg::ST_INTEG : pwa_pkg::ST_ADD;
         end
         pwa_pkg::ST_INTEG: begin
            cmd.act  = pwa_pkg::ACT_INTEG;
            state_in = pwa_pkg::ST_CLAMP;
         end
         pwa_pkg::ST_CLAMP: begin
            cmd.act  = pwa_pkg::ACT_CLAMP;
            op_in    = pwa_pkg::MSRC_GP_E;
            state_in = pwa_pkg::ST_MLO;
         end
         pwa_pkg::ST_ADD: begin
            cmd.act = pwa_pkg::ACT_ADD;
            case (op_ff)
               pwa_pkg::MSRC_GP_E: begin
                  op_in    = pwa_pkg::MSRC_GI_INT;
                  state_in = pwa_pkg::ST_MLO;
               end
               pwa_pkg::MSRC_GI_INT: state_in = pwa_pkg::ST_WAITDIV;
               default:              state_in = pwa_pkg::ST_LIMIT;
            endcase
         end
         pwa_pkg::ST_WAITDIV: begin
            if (!status.div_busy) begin
               state_in = pwa_pkg::ST_QFIX;
            end
         end
         pwa_pkg::ST_QFIX: begin
            cmd.act  = pwa_pkg::ACT_QFIX;
            op_in    = pwa_pkg::MSRC_GD_Q;
            state_in = pwa_pkg::ST_MLO;
         end
         pwa_pkg::ST_LIMIT: begin
            cmd.act  = pwa_pkg::ACT_LIMIT;
            state_in = pwa_pkg::ST_RESID;
         end
         pwa_pkg::ST_RESID: begin
            cmd.act  = pwa_pkg::ACT_RESID;
            state_in = pwa_pkg::ST_SLO;
         end
         pwa_pkg::ST_SLO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_src = pwa_pkg::MSRC_S_SOFT;
            state_in    = pwa_pkg::ST_FIN;
         end
         pwa_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.act  = pwa_pkg::ACT_FIN;
               state_in = pwa_pkg::ST_IDLE;
            end
         end
         default: state_in = pwa_pkg::ST_IDLE;
      endcase

      if (cmd.act == pwa_pkg::ACT_FIN) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == pwa_pkg::ST_LOAD)
      else $error("accepted item did not move to load");
   a_fin_free: assert property (@(posedge clock) disable iff (reset)
      cmd.act == pwa_pkg::ACT_FIN |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote an untaken result");
   a_qfix_div_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == pwa_pkg::ST_QFIX |-> !status.div_busy)
      else $error("quotient used while divider busy");
   a_rsp_after_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pwa_pkg::ST_FIN))
      else $error("result valid without finishing step");
`endif

endmodule

`default_nettype wire

### rtl/pid_with_anti_windup.sv
// One item at a time: a new item is accepted only after the previous step has handed its
// result to the output register. The step runs on a radix-4 serial divider of the derivative
// rate and a shared 33x25 multiplier that forms each product from two partial products.
// Reset (synchronous, active high) restores the register defaults, clears integrator,
// previous error, previous drive and residue, and sets soft start to 0.1.
// Top level of the PID controller; depends on pwa_pkg, pwa_ctrl, pwa_dp and pwa_div.
`default_nettype none

module pid_with_anti_windup #(
   parameter int FRAC_BITS       = 16,
   parameter int BACK_CALC_SHIFT = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   // input items
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pwa_pkg::req_type                req_data,
   // result items
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pwa_pkg::rsp_type                rsp_data,
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pwa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pwa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   pwa_pkg::cmd_type    cmd;
   pwa_pkg::status_type status;

   // registers take a write in any cycle; hold no back-pressure on that port
   assign csr_ready = 1'b1;

   // sequencer: accept an item, step the datapath, drop the result into the output register
   pwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: loop state, multiplier, accumulator, divider and the result payload
   pwa_dp #(
      .FRAC_BITS       (FRAC_BITS),
      .BACK_CALC_SHIFT (BACK_CALC_SHIFT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
